[hw/rtl/tsm_pkg.sv]
// Package for the tricopter motor and yaw servo mixer.
// Holds field widths, mix coefficients, register indexes, stage types and the neutral table.
// No dependencies; every other file of the block imports it.
package tsm_pkg;

    // field and sum widths
    localparam int CMD_W  = 16;
    localparam int PCT_W  = 8;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 34;
    localparam int NQ_W   = 32;

    // unsigned Q0.16 coefficients, held as signed product-width operands
    localparam logic signed [PROD_W-1:0] COEF_SQRT3_3 = 32'sd37837;
    localparam logic signed [PROD_W-1:0] COEF_SQRT3_6 = 32'sd18919;
    localparam logic signed [PROD_W-1:0] COEF_0P7     = 32'sd45875;

    localparam logic [CMD_W-1:0] FULL_SCALE = 16'hFFFF;

    // servo neutral range in percent
    localparam int NEUTRAL_LO   = 25;
    localparam int NEUTRAL_HI   = 75;
    localparam int NEUTRAL_SPAN = NEUTRAL_HI - NEUTRAL_LO + 1;
    localparam int NIDX_W       = $clog2(NEUTRAL_SPAN);
    localparam longint PCT_DIV  = 100;

    // register reset values
    localparam logic [CMD_W-1:0] IDLE_THRUST_RST    = 16'd0;
    localparam logic [CMD_W-1:0] MAX_THRUST_RST     = 16'd60000;
    localparam logic [PCT_W-1:0] SERVO_NEUTRAL_RST  = 8'd50;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_IDLE_THRUST    = 2'd0,
        REG_MAX_THRUST     = 2'd1,
        REG_SERVO_NEUTRAL  = 2'd2,
        REG_SERVO_INVERTED = 2'd3
    } cfg_idx_t;

    // neutral position in Q.16 for each percent from 25 to 75
    typedef logic [NQ_W-1:0] neutral_tab_t [0:NEUTRAL_SPAN-1];

    function automatic neutral_tab_t build_neutral_tab();
        neutral_tab_t tab;
        longint       num;
        for (int i = 0; i < NEUTRAL_SPAN; i++)
        begin
            num    = longint'(NEUTRAL_LO + i) * 64'd65535 * 64'd65536;
            tab[i] = NQ_W'(num / PCT_DIV);
        end
        return tab;
    endfunction

    localparam neutral_tab_t NEUTRAL_TAB = build_neutral_tab();

    // stage 1: conditioned command
    typedef struct packed {
        logic signed [CMD_W-1:0] roll;
        logic signed [CMD_W-1:0] pitch;
        logic signed [CMD_W-1:0] yaw;
        logic [CMD_W-1:0]        thrust;
        logic [NQ_W-1:0]         neutral;
    } cond_t;

    // stage 2: products
    typedef struct packed {
        logic signed [PROD_W-1:0] rear_pitch;
        logic signed [PROD_W-1:0] side_pitch;
        logic signed [PROD_W-1:0] roll_half;
        logic signed [PROD_W-1:0] yaw_term;
        logic [CMD_W-1:0]         thrust;
        logic [NQ_W-1:0]          neutral;
    } prod_t;

    // stage 3: Q.16 sums
    typedef struct packed {
        logic signed [SUM_W-1:0] servo;
        logic signed [SUM_W-1:0] rear;
        logic signed [SUM_W-1:0] left;
        logic signed [SUM_W-1:0] right;
    } sum_t;

    // stage 4: clamped result
    typedef struct packed {
        logic [CMD_W-1:0] servo;
        logic [CMD_W-1:0] rear;
        logic [CMD_W-1:0] left;
        logic [CMD_W-1:0] right;
        logic             capped;
    } res_t;

endpackage

[hw/rtl/tsm_cond.sv]
// Input conditioning stage: thrust limit and servo neutral lookup.
// Depends on tsm_pkg for the stage type and the neutral table.
module tsm_cond
    import tsm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [CMD_W-1:0] roll,
    input  logic signed [CMD_W-1:0] pitch,
    input  logic signed [CMD_W-1:0] yaw,
    input  logic [CMD_W-1:0]        thrust,
    input  logic [CMD_W-1:0]        max_thrust,
    input  logic [PCT_W-1:0]        neutral_pct,
    output logic                    out_valid,
    output cond_t                   out
);

    logic        valid_reg;
    cond_t       data_reg;
    cond_t       data_next;
    logic [PCT_W-1:0]  pct_clamped;
    logic [PCT_W-1:0]  pct_off;
    logic [NIDX_W-1:0] nidx;

    // clamp percent into the usable range and index the table
    always_comb
    begin
        if (neutral_pct > PCT_W'(NEUTRAL_HI))
            pct_clamped = PCT_W'(NEUTRAL_HI);
        else if (neutral_pct < PCT_W'(NEUTRAL_LO))
            pct_clamped = PCT_W'(NEUTRAL_LO);
        else
            pct_clamped = neutral_pct;
        pct_off = pct_clamped - PCT_W'(NEUTRAL_LO);
        nidx    = pct_off[NIDX_W-1:0];
    end

    // limit thrust and assemble the stage word
    always_comb
    begin
        data_next.roll    = roll;
        data_next.pitch   = pitch;
        data_next.yaw     = yaw;
        data_next.thrust  = (thrust > max_thrust) ? max_thrust : thrust;
        data_next.neutral = NEUTRAL_TAB[nidx];
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out       = data_reg;

endmodule

[hw/rtl/tsm_mix.sv]
// Mixing stages: constant-coefficient products, then Q.16 sums per output.
// Depends on tsm_pkg for coefficients and stage types.
module tsm_mix
    import tsm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  cond_t in,
    input  logic  servo_inverted,
    output logic  out_valid,
    output sum_t  out
);

    logic  prod_valid_reg;
    prod_t prod_reg;
    prod_t prod_next;
    logic  sum_valid_reg;
    sum_t  sum_reg;
    sum_t  sum_next;

    logic signed [PROD_W-1:0] pitch_ext;
    logic signed [PROD_W-1:0] yaw_ext;
    logic signed [SUM_W-1:0]  tq;
    logic signed [SUM_W-1:0]  nq;
    logic signed [SUM_W-1:0]  rp;
    logic signed [SUM_W-1:0]  sp;
    logic signed [SUM_W-1:0]  rh;
    logic signed [SUM_W-1:0]  yt;

    // products: one multiplier per coefficient, roll half is a shift
    always_comb
    begin
        pitch_ext = PROD_W'(in.pitch);
        yaw_ext   = PROD_W'(in.yaw);
        prod_next.rear_pitch = PROD_W'(COEF_SQRT3_3 * pitch_ext);
        prod_next.side_pitch = PROD_W'(COEF_SQRT3_6 * pitch_ext);
        prod_next.yaw_term   = PROD_W'(COEF_0P7 * yaw_ext);
        prod_next.roll_half  = {in.roll[CMD_W-1], in.roll, 15'h0000};
        prod_next.thrust     = in.thrust;
        prod_next.neutral    = in.neutral;
    end

    // sums in Q.16
    always_comb
    begin
        tq = $signed({2'b00, prod_reg.thrust, 16'h0000});
        nq = $signed({2'b00, prod_reg.neutral});
        rp = SUM_W'(prod_reg.rear_pitch);
        sp = SUM_W'(prod_reg.side_pitch);
        rh = SUM_W'(prod_reg.roll_half);
        yt = SUM_W'(prod_reg.yaw_term);
        sum_next.rear  = tq - rp;
        sum_next.left  = tq + rh + sp;
        sum_next.right = tq - rh + sp;
        sum_next.servo = servo_inverted ? (nq + yt) : (nq - yt);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out       = sum_reg;

endmodule

[hw/rtl/tsm_sat.sv]
// Output stage: truncate Q.16 sums and clamp, flag overflow at the top.
// Depends on tsm_pkg for stage types; this register is the block's output register.
module tsm_sat
    import tsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  sum_t             in,
    input  logic [CMD_W-1:0] idle_thrust,
    output logic             out_valid,
    output res_t             out
);

    logic valid_reg;
    res_t data_reg;
    res_t data_next;
    logic [CMD_W:0] c_servo;
    logic [CMD_W:0] c_rear;
    logic [CMD_W:0] c_left;
    logic [CMD_W:0] c_right;

    // returns {overflow, value}
    function automatic logic [CMD_W:0] clamp_q16(
        input logic signed [SUM_W-1:0] q,
        input logic [CMD_W-1:0]        lo
    );
        logic [SUM_W-17:0] v;
        logic [CMD_W:0]    r;
        v = q[SUM_W-1] ? '0 : q[SUM_W-1:16];
        if (v < (SUM_W-16)'(lo))
            r = {1'b0, lo};
        else if (v > (SUM_W-16)'(FULL_SCALE))
            r = {1'b1, FULL_SCALE};
        else
            r = {1'b0, v[CMD_W-1:0]};
        return r;
    endfunction

    // clamp each output
    always_comb
    begin
        c_servo = clamp_q16(in.servo, '0);
        c_rear  = clamp_q16(in.rear, idle_thrust);
        c_left  = clamp_q16(in.left, idle_thrust);
        c_right = clamp_q16(in.right, idle_thrust);
        data_next.servo  = c_servo[CMD_W-1:0];
        data_next.rear   = c_rear[CMD_W-1:0];
        data_next.left   = c_left[CMD_W-1:0];
        data_next.right  = c_right[CMD_W-1:0];
        data_next.capped = c_servo[CMD_W] | c_rear[CMD_W] | c_left[CMD_W] | c_right[CMD_W];
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out       = data_reg;

endmodule

[hw/rtl/tri_rotor_servo_mixer.sv]
// Tricopter mixer top level: configuration registers, stall control and stage chain.
// Depends on tsm_pkg, tsm_cond, tsm_mix and tsm_sat.
//
// Usage: one command item (roll, pitch, yaw, thrust) enters on the s_ stream and one
// result item (yaw servo, rear, left and right motor drives, capped flag) leaves on
// the m_ stream for every item accepted, in order.
// Pipeline: four register stages (conditioning, products, sums, clamp); the last one
// is the output register. Throughput is one item per cycle while the output does not
// stall; the chain has no feedback, so the clock rate is limited by the longest
// stage path, such as a multiplier or a 34-bit add.
// Stall: while a result waits in the output register and m_tready is low the whole
// chain holds and s_tready is low; items in flight are kept, none is dropped.
// Bubbles between items stay in the chain as empty slots.
// Configuration: cfg_we writes register cfg_addr with cfg_wdata (truncated to the
// register's width) at the clock edge; write only when no item is in flight.
// Reset: rst_n clears all valid bits and loads idle 0, max thrust 60000, neutral 50
// percent and normal servo direction; there is no clearing pass.
module tri_rotor_servo_mixer
    import tsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // yaw_servo, rear_motor, left_motor, right_motor
    output logic [0:0]  m_tuser,   // capped
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [CMD_W-1:0] idle_thrust_reg;
    logic [CMD_W-1:0] max_thrust_reg;
    logic [PCT_W-1:0] servo_neutral_reg;
    logic             servo_inverted_reg;

    logic  en;
    logic  cond_valid;
    cond_t cond_data;
    logic  sum_valid;
    sum_t  sum_data;
    logic  res_valid;
    res_t  res_data;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_thrust_reg    <= IDLE_THRUST_RST;
            max_thrust_reg     <= MAX_THRUST_RST;
            servo_neutral_reg  <= SERVO_NEUTRAL_RST;
            servo_inverted_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_IDLE_THRUST:    idle_thrust_reg    <= cfg_wdata;
                REG_MAX_THRUST:     max_thrust_reg     <= cfg_wdata;
                REG_SERVO_NEUTRAL:  servo_neutral_reg  <= cfg_wdata[PCT_W-1:0];
                REG_SERVO_INVERTED: servo_inverted_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // chain advances unless a result is held at the output
    assign en       = !res_valid || m_tready;
    assign s_tready = en;

    tsm_cond u_cond (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .roll        ($signed(s_tdata[15:0])),
        .pitch       ($signed(s_tdata[31:16])),
        .yaw         ($signed(s_tdata[47:32])),
        .thrust      (s_tdata[63:48]),
        .max_thrust  (max_thrust_reg),
        .neutral_pct (servo_neutral_reg),
        .out_valid   (cond_valid),
        .out         (cond_data)
    );

    tsm_mix u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (cond_valid),
        .in             (cond_data),
        .servo_inverted (servo_inverted_reg),
        .out_valid      (sum_valid),
        .out            (sum_data)
    );

    tsm_sat u_sat (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (sum_valid),
        .in          (sum_data),
        .idle_thrust (idle_thrust_reg),
        .out_valid   (res_valid),
        .out         (res_data)
    );

    // result stream
    assign m_tvalid = res_valid;
    assign m_tdata  = {res_data.right, res_data.left, res_data.rear, res_data.servo};
    assign m_tuser  = res_data.capped;

    // a capped result has at least one drive at full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] == FULL_SCALE ||
            m_tdata[31:16] == FULL_SCALE || m_tdata[47:32] == FULL_SCALE ||
            m_tdata[63:48] == FULL_SCALE))
        else $error("capped result without a saturated drive");

    // input side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // an accepted item occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> cond_valid)
        else $error("accepted item lost at the first stage");

    // a held result keeps the second-to-last stage frozen as well
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(sum_valid))
        else $error("sum stage moved during an output stall");

endmodule
